/* design/ffac_pkg.sv */
package ffac_pkg;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 32;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int POOL_W       = 17;
    localparam logic [POOL_W-1:0] POOL_RESET = 17'd1024;
    localparam logic [POOL_W-1:0] POOL_MIN   = 17'd64;
    localparam logic [POOL_W-1:0] POOL_MAX   = 17'd65536;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] payload;
        logic        free;
    } t_entry;
endpackage

/* design/ffac_table.sv */
module ffac_table (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ffac_pkg::IDX_W-1:0]   i_waddr,
    input  ffac_pkg::t_entry             i_wdata,
    input  logic [ffac_pkg::IDX_W-1:0]   i_raddr,
    output ffac_pkg::t_entry             o_rdata
);
    ffac_pkg::t_entry r_mem [ffac_pkg::MAX_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/first_fit_allocator_coalescing.sv */
// Channel   Dir  tdata fields (low bit up)                       tuser
// s_axis    in   request_size[15:0], data_offset[31:16]          mode
// m_axis    out  status[1:0], granted_offset[17:2], size[33:18]  -
// cfg       in   pool_bytes[16:0] on i_cfg_wdata, i_cfg_we       -
// A request walks the table one entry at a time, each through a read state and a check
// state (registered memory read), then moves entries one at a time through a read and a
// write state on a split or merge. Reset and a pool_bytes write re-form one free block
// at once. s_axis_tready is low from accept until the result word is taken on m_axis,
// and during reset or a cfg write; a stalled result word holds.
module first_fit_allocator_coalescing (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // request_size, data_offset
    input  logic        s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // status, granted_offset, granted_size
);
    localparam int IW = ffac_pkg::IDX_W;
    localparam int CW = ffac_pkg::CNT_W;
    localparam logic [3:0] S_IDLE = 4'd0, S_SRD = 4'd1, S_SCHK = 4'd2,
        S_SHRD = 4'd3, S_SHWR = 4'd4, S_FIX = 4'd5, S_PRD = 4'd6,
        S_PCHK = 4'd7, S_NRD = 4'd8, S_NCHK = 4'd9, S_RMRD = 4'd10,
        S_RMWR = 4'd11, S_DONE = 4'd12, S_OUT = 4'd13, S_WR2 = 4'd14;

    logic [3:0]    r_state;
    logic [CW-1:0] r_cnt, r_i, r_k, r_rm;
    logic          r_mode;
    logic [15:0]   r_size, r_off;
    ffac_pkg::t_entry r_cur, r_pend;
    logic          r_pend_v;
    logic [1:0]    r_st;
    logic [15:0]   r_go, r_gs;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    ffac_pkg::t_entry wdata, rdata;
    logic [CW-1:0] rsel;

    ffac_table u_tab (.i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata));

    logic [16:0] cfg_v;
    always_comb begin
        cfg_v = i_cfg_wdata;
        if (cfg_v < ffac_pkg::POOL_MIN) cfg_v = ffac_pkg::POOL_MIN;
        if (cfg_v > ffac_pkg::POOL_MAX) cfg_v = ffac_pkg::POOL_MAX;
    end

    logic [16:0] need;
    logic [16:0] hdr_off;
    logic        split_ok;
    assign need    = {1'b0, r_size} + 17'(ffac_pkg::HEADER_BYTES);
    assign hdr_off = {1'b0, rdata.start} + 17'(ffac_pkg::HEADER_BYTES);
    assign split_ok = ({1'b0, rdata.payload} > need) &&
                      (r_cnt < CW'(ffac_pkg::MAX_BLOCKS));

    assign raddr = rsel[IW-1:0];
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n && !i_cfg_we;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {6'd0, r_gs, r_go, r_st};

    always_comb begin
        we = 1'b0; waddr = '0; wdata = r_cur; rsel = r_i;
        unique case (r_state)
            S_SHRD: rsel = r_k - CW'(1);
            S_SHWR: begin we = 1'b1; waddr = r_k[IW-1:0]; wdata = rdata; end
            S_PRD:  rsel = r_i - CW'(1);
            S_NRD:  rsel = r_i + CW'(1);
            S_RMRD: rsel = r_k + CW'(1);
            S_RMWR: begin we = 1'b1; waddr = r_k[IW-1:0]; wdata = rdata; end
            S_FIX:  begin we = 1'b1; waddr = r_i[IW-1:0]; wdata = r_cur; end
            S_WR2:  begin we = 1'b1; waddr = IW'(r_i + CW'(1)); wdata = r_pend; end
            default: ;
        endcase
        if ((!i_rst_n || i_cfg_we) && r_state == S_IDLE) begin
            we = 1'b1; waddr = '0;
            wdata.start = '0; wdata.free = 1'b1;
            wdata.payload = !i_rst_n ? 16'(ffac_pkg::POOL_RESET - 17'(ffac_pkg::HEADER_BYTES))
                                     : 16'(cfg_v - 17'(ffac_pkg::HEADER_BYTES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= CW'(1);
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) r_cnt <= CW'(1);
                    else if (s_axis_tvalid) begin
                        r_mode <= s_axis_tuser; r_size <= s_axis_tdata[15:0];
                        r_off <= s_axis_tdata[31:16]; r_i <= '0;
                        r_st <= ffac_pkg::ST_OK; r_go <= '0; r_gs <= '0;
                        r_pend_v <= 1'b0; r_state <= S_SRD;
                    end
                end
                S_SRD: r_state <= (r_i < r_cnt) ? S_SCHK : S_DONE;
                S_SCHK: begin
                    if (r_mode == ffac_pkg::MODE_ALLOC) begin
                        if (rdata.free && rdata.payload >= r_size) begin
                            r_cur <= '{start: rdata.start,
                                       payload: split_ok ? r_size : rdata.payload,
                                       free: 1'b0};
                            r_go <= 16'(hdr_off);
                            r_gs <= split_ok ? r_size : rdata.payload;
                            if (split_ok) begin
                                r_pend.start <= 16'(hdr_off + {1'b0, r_size});
                                r_pend.payload <= 16'({1'b0, rdata.payload} - need);
                                r_pend.free <= 1'b1; r_pend_v <= 1'b1;
                                r_k <= r_cnt; r_state <= S_SHRD;
                            end else r_state <= S_FIX;
                        end else begin r_i <= r_i + CW'(1); r_state <= S_SRD; end
                    end else begin
                        if (hdr_off == {1'b0, r_off}) begin
                            if (rdata.free) begin
                                r_st <= ffac_pkg::ST_INVALID; r_state <= S_OUT;
                            end else begin
                                r_cur <= '{start: rdata.start, payload: rdata.payload,
                                           free: 1'b1};
                                r_state <= (r_i != '0) ? S_PRD : S_NRD;
                            end
                        end else begin r_i <= r_i + CW'(1); r_state <= S_SRD; end
                    end
                end
                S_SHRD: r_state <= (r_k > r_i + CW'(1)) ? S_SHWR : S_FIX;
                S_SHWR: begin r_k <= r_k - CW'(1); r_state <= S_SHRD; end
                S_FIX: begin
                    if (r_pend_v) begin r_state <= S_WR2; r_cnt <= r_cnt + CW'(1); end
                    else r_state <= S_DONE;
                end
                S_WR2: r_state <= S_DONE;
                S_PRD: r_state <= S_PCHK;
                S_PCHK: begin
                    if (rdata.free) begin
                        r_cur.start <= rdata.start;
                        r_cur.payload <= rdata.payload + r_cur.payload
                                         + 16'(ffac_pkg::HEADER_BYTES);
                        r_rm <= r_i; r_k <= r_i;
                        r_state <= S_RMRD;
                    end else r_state <= S_NRD;
                end
                S_NRD: r_state <= (r_i + CW'(1) < r_cnt) ? S_NCHK : S_FIX;
                S_NCHK: begin
                    if (rdata.free) begin
                        r_cur.payload <= r_cur.payload + rdata.payload
                                         + 16'(ffac_pkg::HEADER_BYTES);
                        r_rm <= r_i + CW'(1); r_k <= r_i + CW'(1);
                        r_state <= S_RMRD;
                    end else r_state <= S_FIX;
                end
                S_RMRD: begin
                    if (r_k + CW'(1) < r_cnt) r_state <= S_RMWR;
                    else begin
                        r_cnt <= r_cnt - CW'(1);
                        if (r_rm == r_i) begin
                            r_i <= r_i - CW'(1); r_state <= S_NRD;
                        end else r_state <= S_FIX;
                    end
                end
                S_RMWR: begin r_k <= r_k + CW'(1); r_state <= S_RMRD; end
                S_DONE: begin
                    if (r_i >= r_cnt && r_mode == ffac_pkg::MODE_ALLOC)
                        r_st <= ffac_pkg::ST_NOSPACE;
                    else if (r_i >= r_cnt) r_st <= ffac_pkg::ST_INVALID;
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* bench/first_fit_allocator_coalescing_tb.sv */
`timescale 1ns / 100ps

module first_fit_allocator_coalescing_tb;
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] offset;
        logic [15:0] size;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [16:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    int unsigned pool_size;
    int unsigned blk_start [ffac_pkg::MAX_BLOCKS];
    int unsigned blk_payload [ffac_pkg::MAX_BLOCKS];
    bit          blk_free [ffac_pkg::MAX_BLOCKS];
    int unsigned blk_count;

    t_grant grant_q[$];
    bit     failed;

    first_fit_allocator_coalescing dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void reform_pool(int unsigned value);
        value = value & 32'h1FFFF;
        if (value < ffac_pkg::POOL_MIN) value = ffac_pkg::POOL_MIN;
        if (value > ffac_pkg::POOL_MAX) value = ffac_pkg::POOL_MAX;
        pool_size = value;
        for (int k = 0; k < ffac_pkg::MAX_BLOCKS; k++) begin
            blk_start[k] = 0;
            blk_payload[k] = 0;
            blk_free[k] = 1'b0;
        end
        blk_payload[0] = pool_size - ffac_pkg::HEADER_BYTES;
        blk_free[0] = 1'b1;
        blk_count = 1;
    endfunction

    function automatic void drop_block(int unsigned idx);
        for (int unsigned k = idx; k + 1 < blk_count; k++) begin
            blk_start[k] = blk_start[k + 1];
            blk_payload[k] = blk_payload[k + 1];
            blk_free[k] = blk_free[k + 1];
        end
        blk_count--;
    endfunction

    function automatic t_grant predict_grant(logic mode, logic [15:0] size, logic [15:0] off);
        t_grant g;
        int unsigned i;
        g = '0;
        if (mode == ffac_pkg::MODE_ALLOC) begin
            for (i = 0; i < blk_count; i++)
                if (blk_free[i] && blk_payload[i] >= size) break;
            if (i >= blk_count) begin
                g.status = ffac_pkg::ST_NOSPACE;
                return g;
            end
            if (blk_payload[i] > size + ffac_pkg::HEADER_BYTES &&
                blk_count < ffac_pkg::MAX_BLOCKS) begin
                for (int unsigned k = blk_count; k > i + 1; k--) begin
                    blk_start[k] = blk_start[k - 1];
                    blk_payload[k] = blk_payload[k - 1];
                    blk_free[k] = blk_free[k - 1];
                end
                blk_start[i + 1] = blk_start[i] + ffac_pkg::HEADER_BYTES + size;
                blk_payload[i + 1] = blk_payload[i] - size - ffac_pkg::HEADER_BYTES;
                blk_free[i + 1] = 1'b1;
                blk_count++;
                blk_payload[i] = size;
            end
            blk_free[i] = 1'b0;
            g.status = ffac_pkg::ST_OK;
            g.offset = 16'(blk_start[i] + ffac_pkg::HEADER_BYTES);
            g.size = 16'(blk_payload[i]);
        end else begin
            for (i = 0; i < blk_count; i++)
                if (blk_start[i] + ffac_pkg::HEADER_BYTES == off) break;
            if (i >= blk_count || blk_free[i]) begin
                g.status = ffac_pkg::ST_INVALID;
                return g;
            end
            blk_free[i] = 1'b1;
            if (i > 0 && blk_free[i - 1]) begin
                blk_payload[i - 1] += blk_payload[i] + ffac_pkg::HEADER_BYTES;
                drop_block(i);
                i--;
            end
            if (i + 1 < blk_count && blk_free[i + 1]) begin
                blk_payload[i] += blk_payload[i + 1] + ffac_pkg::HEADER_BYTES;
                drop_block(i + 1);
            end
            g.status = ffac_pkg::ST_OK;
        end
        return g;
    endfunction

    task automatic send_word(logic mode, logic [15:0] size, logic [15:0] off);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {off, size};
        do @(posedge i_clk); while (!s_axis_tready);
        grant_q.push_back(predict_grant(mode, size, off));
    endtask

    task automatic alloc(logic [15:0] size);
        send_word(ffac_pkg::MODE_ALLOC, size, 16'($urandom));
    endtask

    task automatic release_at(logic [15:0] off);
        send_word(ffac_pkg::MODE_FREE, 16'($urandom), off);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (4 * ffac_pkg::MAX_BLOCKS + 20) @(posedge i_clk);
    endtask

    task automatic set_pool(logic [16:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reform_pool(value);
        @(posedge i_clk);
    endtask

    function automatic int unsigned live_offset();
        int unsigned live[$];
        for (int unsigned k = 0; k < blk_count; k++)
            if (!blk_free[k]) live.push_back(blk_start[k] + ffac_pkg::HEADER_BYTES);
        if (live.size() == 0) return 0;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    task automatic test_reset_pool();
        alloc(16'd0);
        alloc(16'd100);
        alloc(16'hFFFF);
        release_at(16'd32);
        release_at(16'd32);
        release_at(16'd5);
        alloc(16'd0);
        release_at(16'd64);
        release_at(16'd32);
        alloc(16'd992);
        release_at(16'd32);
        alloc(16'd960);
        alloc(16'd0);
        release_at(16'd32);
    endtask

    task automatic test_pool_extremes();
        set_pool(17'd0);
        alloc(16'd32);
        alloc(16'd0);
        release_at(16'd32);
        alloc(16'd33);
        set_pool(17'h1FFFF);
        alloc(16'd65504);
        release_at(16'd32);
        alloc(16'd65535);
        alloc(16'd65471);
        release_at(16'd32);
        set_pool(17'd65536);
    endtask

    task automatic test_table_full();
        set_pool(17'd4096);
        repeat (ffac_pkg::MAX_BLOCKS + 4) alloc(16'd0);
        for (int k = 0; k < ffac_pkg::MAX_BLOCKS; k += 2) release_at(16'(32 + 32 * k));
        for (int k = 1; k < ffac_pkg::MAX_BLOCKS; k += 2) release_at(16'(32 + 32 * k));
        alloc(16'd0);
    endtask

    task automatic test_random(logic [16:0] pool, int count);
        int unsigned pick;
        int unsigned cap;
        set_pool(pool);
        cap = pool_size / 6;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                alloc(16'($urandom_range(0, cap)));
            else if (pick < 50)
                alloc(16'($urandom));
            else if (pick < 88)
                release_at(16'(live_offset()));
            else if (pick < 94)
                release_at(16'(blk_start[$urandom_range(0, blk_count - 1)]
                               + ffac_pkg::HEADER_BYTES));
            else
                release_at(16'($urandom));
        end
    endtask

    initial begin
        forever begin
            int stall;
            t_grant got;
            t_grant want;
            stall = $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready && i_rst_n));
            got.status = m_axis_tdata[1:0];
            got.offset = m_axis_tdata[17:2];
            got.size = m_axis_tdata[33:18];
            if (grant_q.size() == 0) begin
                $error("result word with none expected: %h", m_axis_tdata);
                failed = 1'b1;
            end else begin
                want = grant_q.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    failed = 1'b1;
                end
                if (got.offset !== want.offset) begin
                    $error("granted_offset: expected %0d, got %0d", want.offset, got.offset);
                    failed = 1'b1;
                end
                if (got.size !== want.size) begin
                    $error("granted_size: expected %0d, got %0d", want.size, got.size);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #40000000;
        $display("first_fit_allocator_coalescing regression: fail");
        $finish;
    end

    initial begin
        failed = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        reform_pool(ffac_pkg::POOL_RESET);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_pool();
        test_pool_extremes();
        test_table_full();
        test_random(17'd65536, 250);
        test_random(17'd64, 100);
        test_random(17'd1024, 250);
        test_random(17'(ffac_pkg::POOL_MIN + $urandom_range(0, 65472)), 250);
        test_random(17'd3000, 250);
        test_random(17'd300, 100);
        drain();
        if (!failed)
            $display("first_fit_allocator_coalescing regression: pass");
        else
            $display("first_fit_allocator_coalescing regression: fail");
        $finish;
    end
endmodule

/* files.f */
design/ffac_pkg.sv
design/ffac_table.sv
design/first_fit_allocator_coalescing.sv
bench/first_fit_allocator_coalescing_tb.sv
